FILE: rtl/core/mm_pkg.sv
// Shared types and constants for the matrix multiply block.
// Used by every module under rtl/core; depends on nothing else.
package mm_pkg;

  localparam int FUNC_W    = 2;
  localparam int IDX_W     = 3;   // row and column fields on the ports
  localparam int VAL_W     = 16;  // Q1.15 element
  localparam int PROD_W    = 32;  // Q2.30 product
  localparam int SUM_W     = 40;  // sum of products
  localparam int CFG_W     = 4;
  localparam int CFG_IDX_W = 2;

  localparam logic [FUNC_W-1:0] FUNC_LOAD_A  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_LOAD_B  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_COMPUTE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_A    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS_B    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INNER_LEN = 2'd2;

  localparam logic [CFG_W-1:0] CFG_RESET_DIM = 4'd4;

  typedef logic [IDX_W-1:0]        mm_idx_t;
  typedef logic signed [VAL_W-1:0] mm_val_t;
  typedef logic signed [SUM_W-1:0] mm_sum_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WAIT,
    S_ISSUE
  } seq_state_t;

  typedef struct packed {
    logic [CFG_W-1:0] rows_a;
    logic [CFG_W-1:0] cols_b;
    logic [CFG_W-1:0] inner_len;
  } mm_cfg_t;

  // One multiply step travelling down the MAC pipeline
  typedef struct packed {
    logic    valid;
    logic    first;
    logic    last_k;
    logic    last_elem;
    mm_idx_t row;
    mm_idx_t col;
  } mm_ctl_t;

  typedef struct packed {
    logic    valid;
    logic    last;
    mm_idx_t row;
    mm_idx_t col;
    mm_sum_t sum;
  } mm_res_t;

endpackage

FILE: rtl/core/mm_store.sv
// Element stores for A and B: one write port shared by loads, one read port each.
// Depends on mm_pkg for the element type.
module mm_store import mm_pkg::*; #(
  parameter int MAX_DIM = 8
) (
  input  logic                                 clk,
  input  logic                                 we_a,
  input  logic                                 we_b,
  input  logic [$clog2(MAX_DIM*MAX_DIM)-1:0]   waddr,
  input  mm_val_t                              wdata,
  input  logic [$clog2(MAX_DIM*MAX_DIM)-1:0]   raddr_a,
  input  logic [$clog2(MAX_DIM*MAX_DIM)-1:0]   raddr_b,
  output mm_val_t                              rdata_a,
  output mm_val_t                              rdata_b
);

  localparam int DEPTH = MAX_DIM * MAX_DIM;

  mm_val_t mem_a [DEPTH];
  mm_val_t mem_b [DEPTH];
  mm_val_t rdata_a_r;
  mm_val_t rdata_b_r;

  always_ff @(posedge clk) begin
    if (we_a) begin
      mem_a[waddr] <= wdata;
    end
    rdata_a_r <= mem_a[raddr_a];
  end

  always_ff @(posedge clk) begin
    if (we_b) begin
      mem_b[waddr] <= wdata;
    end
    rdata_b_r <= mem_b[raddr_b];
  end

  assign rdata_a = rdata_a_r;
  assign rdata_b = rdata_b_r;

endmodule

FILE: rtl/core/mm_mac.sv
// Shared multiply-accumulate unit: one product per cycle, accumulated per element.
// Depends on mm_pkg for the control and result structs.
module mm_mac import mm_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  mm_ctl_t issue,    // step issued to the stores this cycle
  input  mm_val_t a_data,   // store data, in the cycle after issue
  input  mm_val_t b_data,
  output logic    busy,
  output mm_res_t res
);

  mm_ctl_t                   d0_r;
  mm_ctl_t                   p_r;
  logic signed [PROD_W-1:0]  product_r;
  mm_sum_t                   acc_r;
  mm_sum_t                   prod_ext;
  mm_sum_t                   sum_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d0_r <= '0;
      p_r  <= '0;
    end else begin
      d0_r <= issue;
      p_r  <= d0_r;
    end
  end

  always_ff @(posedge clk) begin
    if (d0_r.valid) begin
      product_r <= a_data * b_data;
    end
    if (p_r.valid) begin
      acc_r <= sum_nxt;
    end
  end

  always_comb begin
    prod_ext = {{(SUM_W-PROD_W){product_r[PROD_W-1]}}, product_r};
    // restart the sum on the first step of each element
    sum_nxt  = p_r.first ? prod_ext : acc_r + prod_ext;
  end

  assign busy      = d0_r.valid | p_r.valid;
  assign res.valid = p_r.valid & p_r.last_k;
  assign res.last  = p_r.last_elem;
  assign res.row   = p_r.row;
  assign res.col   = p_r.col;
  assign res.sum   = sum_nxt;

endmodule

FILE: rtl/core/mm_seq.sv
// Sequencer: walks i, j, k over the product; one MAC step per S_ISSUE cycle.
// Depends on mm_pkg for states, config and control structs.
module mm_seq import mm_pkg::*; #(
  parameter int MAX_DIM = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  mm_cfg_t                             cfg,
  input  logic                                mac_busy,
  input  logic                                out_full,
  output logic                                idle,
  output mm_ctl_t                             issue,
  output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]  addr_a,
  output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]  addr_b
);

  localparam int CNT_W  = $clog2(MAX_DIM);
  localparam int ADDR_W = $clog2(MAX_DIM * MAX_DIM);

  seq_state_t       state_r, state_nxt;
  logic [CNT_W-1:0] i_r, i_nxt;
  logic [CNT_W-1:0] j_r, j_nxt;
  logic [CNT_W-1:0] k_r, k_nxt;
  logic [CNT_W-1:0] ilim_r, ilim_nxt;
  logic [CNT_W-1:0] jlim_r, jlim_nxt;
  logic [CNT_W-1:0] klim_r, klim_nxt;

  // last index for a dimension register: zero reads as one, large values clamp
  function automatic logic [CNT_W-1:0] lim_of(input logic [CFG_W-1:0] v);
    logic [CNT_W-1:0] r;
    if (v == '0) begin
      r = '0;
    end else if (int'(v) > MAX_DIM) begin
      r = CNT_W'(MAX_DIM - 1);
    end else begin
      r = CNT_W'(v - CFG_W'(1));
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      i_r     <= '0;
      j_r     <= '0;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      k_r     <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ilim_r <= ilim_nxt;
    jlim_r <= jlim_nxt;
    klim_r <= klim_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    k_nxt     = k_r;
    ilim_nxt  = ilim_r;
    jlim_nxt  = jlim_r;
    klim_nxt  = klim_r;
    issue           = '0;
    issue.first     = (k_r == '0);
    issue.last_k    = (k_r == klim_r);
    issue.last_elem = (k_r == klim_r) && (i_r == ilim_r) && (j_r == jlim_r);
    issue.row       = IDX_W'(i_r);
    issue.col       = IDX_W'(j_r);
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          ilim_nxt  = lim_of(cfg.rows_a);
          jlim_nxt  = lim_of(cfg.cols_b);
          klim_nxt  = lim_of(cfg.inner_len);
          i_nxt     = '0;
          j_nxt     = '0;
          k_nxt     = '0;
          state_nxt = S_WAIT;
        end
      end
      S_WAIT: begin
        // hold until the previous element has left the output register
        if (!mac_busy && !out_full) begin
          state_nxt = S_ISSUE;
        end
      end
      S_ISSUE: begin
        issue.valid = 1'b1;
        if (!issue.last_k) begin
          k_nxt = k_r + CNT_W'(1);
        end else begin
          k_nxt = '0;
          if (issue.last_elem) begin
            i_nxt     = '0;
            j_nxt     = '0;
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_WAIT;
            if (j_r == jlim_r) begin
              j_nxt = '0;
              i_nxt = i_r + CNT_W'(1);
            end else begin
              j_nxt = j_r + CNT_W'(1);
            end
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign idle   = (state_r == S_IDLE);
  assign addr_a = ADDR_W'(i_r) * ADDR_W'(MAX_DIM) + ADDR_W'(k_r);
  assign addr_b = ADDR_W'(k_r) * ADDR_W'(MAX_DIM) + ADDR_W'(j_r);

endmodule

FILE: rtl/core/matrix_multiply.sv
// Matrix multiply C = A * B on signed Q1.15 elements, up to MAX_DIM by MAX_DIM.
// Depends on mm_pkg, mm_store, mm_mac and mm_seq.
//
// Input words: in_tuser carries the function (load A, load B, compute).
// A load writes one element at (row, col); a load with row or col at MAX_DIM
// or above is dropped. A compute word walks the result in row-major order and
// sends one output word per element of C, out_tlast on the final one. The
// dimensions come from the cfg port (rows_a, cols_b, inner_len); the user must
// see that they are written only while the block is idle, as the block does
// not enforce this. 0 reads as 1 and values above MAX_DIM clamp.
// The single 16x16 multiplier takes one step per cycle while an element is
// issuing; before each element the sequencer waits until the MAC pipeline
// and the output register are empty. in_tready stays low while a compute is
// issuing and returns once the last step is issued.
// A stalled receiver holds the output word; the next element waits for it.
// Reset clears control state and sets all three dimensions to 4; the element
// stores are undefined until loaded.
module matrix_multiply import mm_pkg::*; #(
  parameter int MAX_DIM = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [23:0]           in_tdata,   // row[2:0], col[5:3], value[21:6], zero pad
  input  logic [FUNC_W-1:0]     in_tuser,   // func[1:0]
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [47:0]           out_tdata,  // sum[39:0], out_row[42:40], out_col[45:43], pad
  output logic                  out_tlast,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_data
);

  localparam int ADDR_W = $clog2(MAX_DIM * MAX_DIM);

  mm_cfg_t           cfg_r;
  mm_idx_t           in_row;
  mm_idx_t           in_col;
  mm_val_t           in_value;
  logic              in_fire;
  logic              load_ok;
  logic              we_a;
  logic              we_b;
  logic              start;
  logic [ADDR_W-1:0] waddr;
  logic [ADDR_W-1:0] addr_a;
  logic [ADDR_W-1:0] addr_b;
  mm_val_t           rdata_a;
  mm_val_t           rdata_b;
  mm_ctl_t           issue;
  logic              mac_busy;
  mm_res_t           res;
  logic              idle;
  logic              out_valid_r;
  logic              out_last_r;
  mm_idx_t           out_row_r;
  mm_idx_t           out_col_r;
  mm_sum_t           out_sum_r;

  assign in_row   = in_tdata[2:0];
  assign in_col   = in_tdata[5:3];
  assign in_value = in_tdata[21:6];

  assign in_tready = idle;
  assign in_fire   = in_tvalid & in_tready;
  assign load_ok   = (int'(in_row) < MAX_DIM) && (int'(in_col) < MAX_DIM);
  assign we_a      = in_fire && load_ok && (in_tuser == FUNC_LOAD_A);
  assign we_b      = in_fire && load_ok && (in_tuser == FUNC_LOAD_B);
  assign start     = in_fire && (in_tuser == FUNC_COMPUTE);
  assign waddr     = ADDR_W'(in_row) * ADDR_W'(MAX_DIM) + ADDR_W'(in_col);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.rows_a    <= CFG_RESET_DIM;
      cfg_r.cols_b    <= CFG_RESET_DIM;
      cfg_r.inner_len <= CFG_RESET_DIM;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_ROWS_A:    cfg_r.rows_a    <= cfg_data;
        CFG_COLS_B:    cfg_r.cols_b    <= cfg_data;
        CFG_INNER_LEN: cfg_r.inner_len <= cfg_data;
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  mm_store #(.MAX_DIM(MAX_DIM)) u_store (
    .clk     (clk),
    .we_a    (we_a),
    .we_b    (we_b),
    .waddr   (waddr),
    .wdata   (in_value),
    .raddr_a (addr_a),
    .raddr_b (addr_b),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  mm_seq #(.MAX_DIM(MAX_DIM)) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .cfg      (cfg_r),
    .mac_busy (mac_busy),
    .out_full (out_valid_r),
    .idle     (idle),
    .issue    (issue),
    .addr_a   (addr_a),
    .addr_b   (addr_b)
  );

  mm_mac u_mac (
    .clk    (clk),
    .rst_n  (rst_n),
    .issue  (issue),
    .a_data (rdata_a),
    .b_data (rdata_b),
    .busy   (mac_busy),
    .res    (res)
  );

  // output word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res.valid) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      out_sum_r  <= res.sum;
      out_row_r  <= res.row;
      out_col_r  <= res.col;
      out_last_r <= res.last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_col_r, out_row_r, out_sum_r};
  assign out_tlast  = out_last_r;

  // a finished element never lands on a word still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid |-> !out_valid_r)
    else $error("result overwrote a pending output word");

  // no input word is taken while steps are being issued
  a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
    issue.valid |-> !in_tready)
    else $error("input accepted during compute issue");

  // the first step of an element starts only with the output path empty
  a_issue_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (issue.valid && issue.first) |-> (!out_valid_r && !mac_busy))
    else $error("element issued while previous one in flight");

endmodule
